>>> rtl/core/skts_pkg.sv
// skts_pkg: shared types and constants of the sorted key table search block
// used by skts_step, the top level and the bench; depends on nothing
`timescale 1ns / 1ps

package skts_pkg;

  // defaults for the top level parameters
  localparam int TABLE_DEPTH_DEFAULT = 4096;
  localparam int KEY_BYTES_DEFAULT   = 8;

  // fixed field widths
  localparam int IDX_W = 12;
  localparam int KEY_W = 64;
  localparam int OFF_W = 18;
  localparam int CNT_W = 13;

  // item opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // payload of one item as it moves down the search pipeline
  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] widx;
    logic [KEY_W-1:0] key;
    logic [OFF_W-1:0] offs;
    logic             found;
    logic [IDX_W-1:0] midx;
    logic [OFF_W-1:0] moff;
  } item_t;

endpackage

>>> rtl/core/skts_ram.sv
// skts_ram: generic one-write one-read ram with registered read data
// standalone, no package needed
`timescale 1ns / 1ps

module skts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/skts_step.sv
// skts_step: one halving step of the search, two register stages and a table copy
// depends on skts_pkg and skts_ram
`timescale 1ns / 1ps

module skts_step #(
  parameter int TABLE_DEPTH = skts_pkg::TABLE_DEPTH_DEFAULT,
  parameter int KEY_BYTES   = skts_pkg::KEY_BYTES_DEFAULT,
  localparam int PW = $clog2(TABLE_DEPTH + 1),
  localparam int IW = $clog2(TABLE_DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  skts_pkg::item_t       in_item_i,
  input  logic [PW-1:0]         in_low_i,
  input  logic [PW-1:0]         in_hi_i,
  output logic                  out_valid_o,
  output skts_pkg::item_t       out_item_o,
  output logic [PW-1:0]         out_low_o,
  output logic [PW-1:0]         out_hi_o
);

  localparam int KW = 8 * KEY_BYTES;
  localparam int RW = KW + skts_pkg::OFF_W;

  logic [PW:0]     mid_sum;
  logic [PW-1:0]   mid;
  logic            act;
  logic            wr_en;
  logic [RW-1:0]   rd_data;
  logic [KW-1:0]   probe_key;
  logic [KW-1:0]   item_key;

  logic            b_valid_q;
  logic            b_act_q;
  skts_pkg::item_t b_item_q;
  logic [PW-1:0]   b_low_q;
  logic [PW-1:0]   b_hi_q;
  logic [PW-1:0]   b_mid_q;

  skts_pkg::item_t nx_item;
  logic [PW-1:0]   nx_low;
  logic [PW-1:0]   nx_hi;

  logic            out_valid_q;
  skts_pkg::item_t out_item_q;
  logic [PW-1:0]   out_low_q;
  logic [PW-1:0]   out_hi_q;

  // middle of the open range, range is [low, hi)
  assign mid_sum = {1'b0, in_low_i} + {1'b0, in_hi_i} - 1'b1;
  assign mid     = mid_sum[PW:1];
  assign act     = in_valid_i && (in_item_i.op == skts_pkg::OP_SEARCH) &&
                   !in_item_i.found && (in_low_i < in_hi_i);

  // a write item updates this step's table copy as it passes
  assign wr_en = in_valid_i && (in_item_i.op == skts_pkg::OP_WRITE) &&
                 (32'(in_item_i.widx) < 32'(TABLE_DEPTH));

  skts_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (IW'(in_item_i.widx)),
    .wdata_i ({in_item_i.key[63 -: KW], in_item_i.offs}),
    .raddr_i (mid[IW-1:0]),
    .rdata_o (rd_data)
  );

  // probe stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_act_q   <= 1'b0;
    end else begin
      b_valid_q <= in_valid_i;
      b_act_q   <= act;
    end
  end

  // probe stage payload
  always_ff @(posedge clk_i) begin
    b_item_q <= in_item_i;
    b_low_q  <= in_low_i;
    b_hi_q   <= in_hi_i;
    b_mid_q  <= mid;
  end

  // compare with the probed entry and narrow the range
  assign probe_key = rd_data[RW-1:skts_pkg::OFF_W];
  assign item_key  = b_item_q.key[63 -: KW];

  always_comb begin
    nx_item = b_item_q;
    nx_low  = b_low_q;
    nx_hi   = b_hi_q;
    if (b_act_q) begin
      if (item_key == probe_key) begin
        nx_item.found = 1'b1;
        nx_item.midx  = skts_pkg::IDX_W'(b_mid_q);
        nx_item.moff  = rd_data[skts_pkg::OFF_W-1:0];
      end else if (item_key < probe_key) begin
        nx_hi = b_mid_q;
      end else begin
        nx_low = PW'({1'b0, b_mid_q} + 1'b1);
      end
    end
  end

  // step output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= nx_item;
    out_low_q  <= nx_low;
    out_hi_q   <= nx_hi;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign out_low_o   = out_low_q;
  assign out_hi_o    = out_hi_q;

endmodule

>>> rtl/core/sorted_key_table_search_top.sv
// sorted_key_table_search_top: pipelined binary search over a sorted key table
// depends on skts_pkg, skts_step and skts_ram
`timescale 1ns / 1ps

// Usage
//   An item is taken at a rising edge with start_i high and busy_o low. busy_o
//   stays low: a new item may enter in every cycle. opcode_i selects a write
//   (store lookup_key_i and text_offset_i at entry_index_i, no result) or a
//   search for lookup_key_i.
//   entry_count must be written through cfg_we_i / cfg_wdata_i only while no
//   item is in flight; the block does not enforce this. Searches cover entries
//   0 to entry_count-1, or the whole table if entry_count exceeds TABLE_DEPTH.
//   Each search gives one result on found_o, match_index_o and match_offset_o,
//   marked by valid_o for exactly one cycle; there is no back pressure. Items
//   pass the entry register, one pipeline step per halving, each with a ram
//   read and a compare stage, and the result register, at one item per cycle.
//   Every step holds its own copy of the table, and writes update each copy as
//   they pass, so every item sees the table as left by the items before it.
//   Reset clears the pipeline valid bits and entry_count; table contents stay
//   undefined until written. No clearing pass is run.

module sorted_key_table_search_top #(
  parameter int TABLE_DEPTH = skts_pkg::TABLE_DEPTH_DEFAULT,
  parameter int KEY_BYTES   = skts_pkg::KEY_BYTES_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        opcode_i,
  input  logic [skts_pkg::IDX_W-1:0]  entry_index_i,
  input  logic [skts_pkg::KEY_W-1:0]  lookup_key_i,
  input  logic [skts_pkg::OFF_W-1:0]  text_offset_i,
  input  logic                        cfg_we_i,
  input  logic [skts_pkg::CNT_W-1:0]  cfg_wdata_i,
  output logic                        valid_o,
  output logic                        found_o,
  output logic [skts_pkg::IDX_W-1:0]  match_index_o,
  output logic [skts_pkg::OFF_W-1:0]  match_offset_o
);

  localparam int PW    = $clog2(TABLE_DEPTH + 1);
  localparam int STEPS = $clog2(TABLE_DEPTH + 1);
  localparam int LAT   = 2 * STEPS + 2;

  logic [skts_pkg::CNT_W-1:0] cnt_q;
  logic [PW-1:0]              cnt_clamp;

  logic                       valid_w [STEPS+1];
  skts_pkg::item_t            item_w  [STEPS+1];
  logic [PW-1:0]              low_w   [STEPS+1];
  logic [PW-1:0]              hi_w    [STEPS+1];

  logic                       in_valid_q;
  skts_pkg::item_t            in_item_q;
  logic [PW-1:0]              in_hi_q;

  logic                       res_valid_q;
  logic                       res_found_q;
  logic [skts_pkg::IDX_W-1:0] res_idx_q;
  logic [skts_pkg::OFF_W-1:0] res_off_q;

  assign busy_o = 1'b0;

  // entry count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cfg_we_i) begin
      cnt_q <= cfg_wdata_i;
    end
  end

  // counts beyond the table depth search the whole table
  assign cnt_clamp = (32'(cnt_q) > 32'(TABLE_DEPTH)) ? PW'(TABLE_DEPTH) : PW'(cnt_q);

  // entry register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    in_item_q.op    <= opcode_i;
    in_item_q.widx  <= entry_index_i;
    in_item_q.key   <= lookup_key_i;
    in_item_q.offs  <= text_offset_i;
    in_item_q.found <= 1'b0;
    in_item_q.midx  <= '0;
    in_item_q.moff  <= '0;
    in_hi_q         <= cnt_clamp;
  end

  assign valid_w[0] = in_valid_q;
  assign item_w[0]  = in_item_q;
  assign low_w[0]   = '0;
  assign hi_w[0]    = in_hi_q;

  // one halving step per stage pair
  for (genvar s = 0; s < STEPS; s++) begin : g_step
    skts_step #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BYTES   (KEY_BYTES)
    ) u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid_w[s]),
      .in_item_i   (item_w[s]),
      .in_low_i    (low_w[s]),
      .in_hi_i     (hi_w[s]),
      .out_valid_o (valid_w[s+1]),
      .out_item_o  (item_w[s+1]),
      .out_low_o   (low_w[s+1]),
      .out_hi_o    (hi_w[s+1])
    );
  end

  // result register, search items only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= valid_w[STEPS] && (item_w[STEPS].op == skts_pkg::OP_SEARCH);
    end
  end

  always_ff @(posedge clk_i) begin
    res_found_q <= item_w[STEPS].found;
    res_idx_q   <= item_w[STEPS].midx;
    res_off_q   <= item_w[STEPS].moff;
  end

  assign valid_o        = res_valid_q;
  assign found_o        = res_found_q;
  assign match_index_o  = res_idx_q;
  assign match_offset_o = res_off_q;

`ifndef SYNTHESIS
  // a search item gives its result once it has passed the pipeline
  a_search_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && opcode_i == skts_pkg::OP_SEARCH) |-> ##LAT valid_o)
    else $error("search item gave no result");

  // a write item gives no result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && opcode_i == skts_pkg::OP_WRITE) |-> ##LAT !valid_o)
    else $error("write item gave a result");

  // a miss reports zero index and offset
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !found_o) |-> (match_index_o == '0 && match_offset_o == '0))
    else $error("miss with nonzero index or offset");

  // the search range never ends beyond the table
  a_range_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |-> (32'(in_hi_q) <= 32'(TABLE_DEPTH)))
    else $error("search range exceeds table depth");
`endif

endmodule

>>> bench/sorted_key_table_search_checker.sv
// sorted_key_table_search_checker: watches the item, config and result ports,
// predicts every search result and compares it; depends on skts_pkg
`timescale 1ns / 1ps

module sorted_key_table_search_checker #(
  parameter int TABLE_DEPTH = 4096,
  parameter int KEY_BYTES   = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_o,
  input  logic                        opcode_i,
  input  logic [skts_pkg::IDX_W-1:0]  entry_index_i,
  input  logic [skts_pkg::KEY_W-1:0]  lookup_key_i,
  input  logic [skts_pkg::OFF_W-1:0]  text_offset_i,
  input  logic                        cfg_we_i,
  input  logic [skts_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic                        valid_o,
  input  logic                        found_o,
  input  logic [skts_pkg::IDX_W-1:0]  match_index_o,
  input  logic [skts_pkg::OFF_W-1:0]  match_offset_o,
  output int                          fail_count_o,
  output int                          pending_o
);

  typedef struct packed {
    logic                       found;
    logic [skts_pkg::IDX_W-1:0] idx;
    logic [skts_pkg::OFF_W-1:0] offs;
  } lookup_result_t;

  // own copy of the table and the entry count register
  logic [skts_pkg::KEY_W-1:0] stored_keys    [TABLE_DEPTH];
  logic [skts_pkg::OFF_W-1:0] stored_offsets [TABLE_DEPTH];
  logic [skts_pkg::CNT_W-1:0] entry_count;

  lookup_result_t expected_lookups [$];
  lookup_result_t want;
  int             fails;

  // binary search over entries 0 .. count-1, on the masked key bytes
  function automatic lookup_result_t predict_lookup(
    input logic [skts_pkg::KEY_W-1:0] key
  );
    lookup_result_t             res;
    logic [skts_pkg::KEY_W-1:0] kmask;
    logic [skts_pkg::KEY_W-1:0] probe;
    int unsigned                cnt;
    int                         lo;
    int                         hi;
    int                         mid;
    res   = '0;
    kmask = '1;
    kmask = kmask << (skts_pkg::KEY_W - 8 * KEY_BYTES);
    cnt   = entry_count;
    if (cnt > TABLE_DEPTH) cnt = TABLE_DEPTH;
    lo  = 0;
    hi  = int'(cnt) - 1;
    key = key & kmask;
    while (lo <= hi && !res.found) begin
      mid   = (lo + hi) / 2;
      probe = stored_keys[mid] & kmask;
      if (key == probe) begin
        res.found = 1'b1;
        res.idx   = skts_pkg::IDX_W'(mid);
        res.offs  = stored_offsets[mid];
      end else if (key < probe) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return res;
  endfunction

  // compare results, then track config writes and accepted items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count = '0;
      expected_lookups.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (valid_o) begin
        if (expected_lookups.size() == 0) begin
          $error("result with no search waiting: found %0d index %0d offset %0h",
                 found_o, match_index_o, match_offset_o);
          fails++;
        end else begin
          want = expected_lookups.pop_front();
          if (found_o !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found_o);
            fails++;
          end
          if (match_index_o !== want.idx) begin
            $error("match_index: expected %0d, actual %0d", want.idx, match_index_o);
            fails++;
          end
          if (match_offset_o !== want.offs) begin
            $error("match_offset: expected %0h, actual %0h", want.offs, match_offset_o);
            fails++;
          end
        end
      end
      if (cfg_we_i) entry_count = cfg_wdata_i;
      if (start_i && !busy_o) begin
        if (opcode_i == skts_pkg::OP_WRITE) begin
          if (entry_index_i < TABLE_DEPTH) begin
            stored_keys[entry_index_i]    = lookup_key_i;
            stored_offsets[entry_index_i] = text_offset_i;
          end
        end else begin
          expected_lookups.push_back(predict_lookup(lookup_key_i));
        end
      end
      fail_count_o <= fails;
      pending_o    <= expected_lookups.size();
    end
  end

endmodule

>>> bench/tb_sorted_key_table_search_top.sv
// tb_sorted_key_table_search_top: drives table writes, searches and entry
// count settings into the block; depends on skts_pkg, the block and the checker
`timescale 1ns / 1ps

module tb_sorted_key_table_search_top;

  localparam int DEPTH          = 4096;
  localparam int KBYTES         = 8;
  localparam int FILL           = 256;
  localparam int LATENCY        = 2 * $clog2(DEPTH + 1) + 2;
  localparam int SETTLE         = LATENCY + 12;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic                       opcode_i;
  logic [skts_pkg::IDX_W-1:0] entry_index_i;
  logic [skts_pkg::KEY_W-1:0] lookup_key_i;
  logic [skts_pkg::OFF_W-1:0] text_offset_i;
  logic                       cfg_we_i;
  logic [skts_pkg::CNT_W-1:0] cfg_wdata_i;
  logic                       valid_o;
  logic                       found_o;
  logic [skts_pkg::IDX_W-1:0] match_index_o;
  logic [skts_pkg::OFF_W-1:0] match_offset_o;

  int fail_count;
  int pending_results;
  int idle_cycles;
  int burst_left;

  // keys as written so far, used to aim searches at present keys
  logic [skts_pkg::KEY_W-1:0] stim_keys [DEPTH];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sorted_key_table_search_top #(
    .TABLE_DEPTH (DEPTH),
    .KEY_BYTES   (KBYTES)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .entry_index_i  (entry_index_i),
    .lookup_key_i   (lookup_key_i),
    .text_offset_i  (text_offset_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .valid_o        (valid_o),
    .found_o        (found_o),
    .match_index_o  (match_index_o),
    .match_offset_o (match_offset_o)
  );

  sorted_key_table_search_checker #(
    .TABLE_DEPTH (DEPTH),
    .KEY_BYTES   (KBYTES)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .entry_index_i  (entry_index_i),
    .lookup_key_i   (lookup_key_i),
    .text_offset_i  (text_offset_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .valid_o        (valid_o),
    .found_o        (found_o),
    .match_index_o  (match_index_o),
    .match_offset_o (match_offset_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_results)
  );

  // watchdog on cycles with no item and no result
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((start_i && !busy_o) || valid_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  // sender gap: mostly none, some short, a few long, with gapless bursts
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      burst_left = 40;
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // present one item and hold it until taken
  task automatic send_item(input logic op, input logic [skts_pkg::IDX_W-1:0] idx,
                           input logic [skts_pkg::KEY_W-1:0] key,
                           input logic [skts_pkg::OFF_W-1:0] offs);
    int gap;
    start_i       <= 1'b1;
    opcode_i      <= op;
    entry_index_i <= idx;
    lookup_key_i  <= key;
    text_offset_i <= offs;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_entry(input logic [skts_pkg::IDX_W-1:0] idx,
                             input logic [skts_pkg::KEY_W-1:0] key,
                             input logic [skts_pkg::OFF_W-1:0] offs);
    stim_keys[idx] = key;
    send_item(skts_pkg::OP_WRITE, idx, key, offs);
  endtask

  // search item, unused fields carry noise
  task automatic search_key(input logic [skts_pkg::KEY_W-1:0] key);
    send_item(skts_pkg::OP_SEARCH, skts_pkg::IDX_W'($urandom), key,
              skts_pkg::OFF_W'($urandom));
  endtask

  // stop sending until all results are in and writes have drained
  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [skts_pkg::CNT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // random mix of hits, near misses, wild keys and table rewrites
  // counts are either at most FILL or at least DEPTH, so every probe lands
  // on the filled low part or on the all-ones spine entries above it
  task automatic run_phase(input int unsigned count, input int n_items);
    int unsigned                live;
    int unsigned                idx;
    int unsigned                w;
    int                         r;
    int                         i;
    logic [skts_pkg::KEY_W-1:0] k;
    wait_idle();
    write_count(skts_pkg::CNT_W'(count));
    live = (count > FILL) ? FILL : count;
    for (i = 0; i < n_items; i++) begin
      r   = $urandom_range(99);
      idx = (live > 0) ? $urandom_range(live - 1) : 0;
      // the top filled entry keeps its all-ones key
      w   = $urandom_range(FILL - 2);
      if (r < 2) wait_idle();
      if (r < 12) begin
        // same key, new offset: order kept
        write_entry(skts_pkg::IDX_W'(w), stim_keys[w], skts_pkg::OFF_W'($urandom));
      end else if (r < 16) begin
        // arbitrary key: may leave the table unsorted
        write_entry(skts_pkg::IDX_W'(w), {$urandom, $urandom},
                    skts_pkg::OFF_W'($urandom));
      end else if (r < 60) begin
        search_key((live > 0) ? stim_keys[idx] : {$urandom, $urandom});
      end else if (r < 75) begin
        k = stim_keys[idx];
        k = ($urandom_range(1) != 0) ? k + 64'd1 : k - 64'd1;
        search_key(k);
      end else if (r < 79) begin
        search_key(($urandom_range(1) != 0) ? '1 : '0);
      end else begin
        search_key({$urandom, $urandom});
      end
    end
  endtask

  initial begin : stimulus
    int                         i;
    int                         p;
    logic [skts_pkg::KEY_W-1:0] k;
    burst_left     = 0;
    rst_ni        <= 1'b0;
    start_i       <= 1'b0;
    opcode_i      <= skts_pkg::OP_WRITE;
    entry_index_i <= '0;
    lookup_key_i  <= '0;
    text_offset_i <= '0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table after reset
    search_key('0);
    search_key('1);

    // small sorted table with extreme keys and keys holding zero bytes
    write_entry(12'd0, 64'h0000_0000_0000_0000, 18'h00000);
    write_entry(12'd1, 64'h0000_0000_0000_0001, 18'h00001);
    write_entry(12'd2, 64'h4100_4200_0000_0000, 18'h15555);
    write_entry(12'd3, 64'h4142_4300_0000_0000, 18'h2AAAA);
    write_entry(12'd4, 64'h4142_4344_4546_4748, 18'h01234);
    write_entry(12'd5, 64'h7FFF_FFFF_FFFF_FFFF, 18'h1FFFF);
    write_entry(12'd6, 64'h8000_0000_0000_0000, 18'h20000);
    write_entry(12'd7, 64'hFFFF_FFFF_FFFF_FFFF, 18'h3FFFF);
    wait_idle();
    write_count(13'd8);
    search_key(64'h0000_0000_0000_0000);
    search_key(64'hFFFF_FFFF_FFFF_FFFF);
    search_key(64'h4142_4300_0000_0000);
    search_key(64'h4100_4200_0000_0000);
    // prefix of a stored key, trailing bytes differ, gap between entries
    search_key(64'h4100_0000_0000_0000);
    search_key(64'h4100_4200_0000_0001);
    search_key(64'hC000_0000_0000_0000);
    // rewrite then search back to back
    write_entry(12'd3, 64'h4142_4300_0000_0000, 18'h3FFFE);
    search_key(64'h4142_4300_0000_0000);
    wait_idle();
    write_count(13'd1);
    search_key(64'h0000_0000_0000_0000);
    search_key(64'h0000_0000_0000_0001);

    // fill the low part in order: position in the top bits, random below
    for (i = 0; i < FILL; i++) begin
      k = {$urandom, $urandom};
      k[skts_pkg::KEY_W-1 -: skts_pkg::IDX_W] = skts_pkg::IDX_W'(i);
      if (i == 0) k = '0;
      if (i == FILL - 1) k = '1;
      write_entry(skts_pkg::IDX_W'(i), k, skts_pkg::OFF_W'($urandom));
    end

    // all-ones spine entries steer full-table searches down to the low part
    for (p = DEPTH / 2; p > FILL; p = p / 2) begin
      write_entry(skts_pkg::IDX_W'(p - 1), '1, skts_pkg::OFF_W'($urandom));
    end

    run_phase(DEPTH, 50);
    run_phase(8191, 45);
    run_phase($urandom_range(8190, DEPTH + 1), 45);
    run_phase($urandom_range(FILL, 2), 50);
    run_phase(2, 35);
    run_phase(1, 30);
    run_phase(0, 20);
    run_phase(FILL, 50);

    wait_idle();
    if (fail_count == 0 && pending_results == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/skts_pkg.sv
rtl/core/skts_ram.sv
rtl/core/skts_step.sv
rtl/core/sorted_key_table_search_top.sv
bench/sorted_key_table_search_checker.sv
bench/tb_sorted_key_table_search_top.sv
